@@ rtl/core/rebc_pkg.sv @@
package rebc_pkg;

    localparam int TIME_W   = 64;
    localparam int QUIET_W  = 20;
    localparam int COUNT_W  = 32;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    localparam logic [QUIET_W-1:0] EDGE_QUIET_RESET   = 20'd1000;
    localparam logic [QUIET_W-1:0] BUTTON_QUIET_RESET = 20'd50000;

    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_BUTTON = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_EDGE_QUIET   = 1'b0,
        REG_BUTTON_QUIET = 1'b1
    } reg_idx_t;

    // transition codes: {b_new, a_new, b_old, a_old}
    localparam logic [3:0] CODE_UP_0   = 4'd3;
    localparam logic [3:0] CODE_UP_1   = 4'd12;
    localparam logic [3:0] CODE_DOWN_0 = 4'd6;
    localparam logic [3:0] CODE_DOWN_1 = 4'd9;

    typedef struct packed {
        cmd_t              cmd;
        logic [TIME_W-1:0] time_us;
        logic              phase_a;
        logic              phase_b;
    } item_t;

endpackage

@@ rtl/core/rebc_in_reg.sv @@
module rebc_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rebc_pkg::item_t in_item,
    output logic           item_valid,
    input  logic           item_take,
    output rebc_pkg::item_t item
);
    import rebc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/core/rebc_core.sv @@
module rebc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  rebc_pkg::reg_idx_t            cfg_index,
    input  logic [rebc_pkg::QUIET_W-1:0]  cfg_data,
    input  logic                          item_valid,
    output logic                          item_take,
    input  rebc_pkg::item_t               item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rebc_pkg::COUNT_W-1:0]  out_position,
    output logic [rebc_pkg::COUNT_W-1:0]  out_presses
);
    import rebc_pkg::*;

    logic [QUIET_W-1:0] edge_quiet_reg;
    logic [QUIET_W-1:0] button_quiet_reg;

    logic [1:0]         prev_phase_reg,   prev_phase_next;
    logic [COUNT_W-1:0] net_steps_reg,    net_steps_next;
    logic [COUNT_W-1:0] press_total_reg,  press_total_next;
    logic [TIME_W-1:0]  last_edge_reg,    last_edge_next;
    logic [TIME_W-1:0]  last_press_reg,   last_press_next;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_position_reg;
    logic [COUNT_W-1:0] out_presses_reg;

    logic [TIME_W:0]    edge_limit;
    logic [TIME_W:0]    press_limit;
    logic               edge_too_soon;
    logic               press_too_soon;
    logic [3:0]         code;
    logic               is_read;

    // limits kept one bit wider so the sum never wraps
    assign edge_limit  = {1'b0, last_edge_reg}  + {{(TIME_W+1-QUIET_W){1'b0}}, edge_quiet_reg};
    assign press_limit = {1'b0, last_press_reg} + {{(TIME_W+1-QUIET_W){1'b0}}, button_quiet_reg};
    assign edge_too_soon  = {1'b0, item.time_us} < edge_limit;
    assign press_too_soon = {1'b0, item.time_us} < press_limit;
    assign code = {item.phase_b, item.phase_a, prev_phase_reg};

    assign is_read   = (item.cmd == CMD_READ);
    assign item_take = item_valid && (!is_read || !out_valid_reg || out_ready);

    assign out_valid    = out_valid_reg;
    assign out_position = out_position_reg;
    assign out_presses  = out_presses_reg;

    always_comb
    begin
        prev_phase_next  = prev_phase_reg;
        net_steps_next   = net_steps_reg;
        press_total_next = press_total_reg;
        last_edge_next   = last_edge_reg;
        last_press_next  = last_press_reg;
        if (item_take)
        begin
            unique case (item.cmd)
                CMD_EDGE:
                begin
                    if (!edge_too_soon)
                    begin
                        case (code) inside
                            CODE_UP_0, CODE_UP_1:
                                net_steps_next = net_steps_reg + COUNT_W'(1);
                            CODE_DOWN_0, CODE_DOWN_1:
                                net_steps_next = net_steps_reg - COUNT_W'(1);
                            default:
                                net_steps_next = net_steps_reg;
                        endcase
                        prev_phase_next = code[3:2];
                    end
                    last_edge_next = item.time_us;
                end
                CMD_BUTTON:
                begin
                    if (!press_too_soon)
                    begin
                        press_total_next = press_total_reg + COUNT_W'(1);
                        last_press_next  = item.time_us;
                    end
                end
                CMD_READ:
                begin
                    net_steps_next   = '0;
                    press_total_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_quiet_reg   <= EDGE_QUIET_RESET;
            button_quiet_reg <= BUTTON_QUIET_RESET;
            prev_phase_reg   <= '0;
            net_steps_reg    <= '0;
            press_total_reg  <= '0;
            last_edge_reg    <= '0;
            last_press_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_EDGE_QUIET:   edge_quiet_reg   <= cfg_data;
                    REG_BUTTON_QUIET: button_quiet_reg <= cfg_data;
                    default:          edge_quiet_reg   <= edge_quiet_reg;
                endcase
            end
            prev_phase_reg  <= prev_phase_next;
            net_steps_reg   <= net_steps_next;
            press_total_reg <= press_total_next;
            last_edge_reg   <= last_edge_next;
            last_press_reg  <= last_press_next;
            if (item_take && is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && is_read)
        begin
            out_position_reg <= net_steps_reg;
            out_presses_reg  <= press_total_reg;
        end
    end

endmodule

@@ rtl/core/rotary_encoder_with_button_counter.sv @@
// Quadrature encoder decoder with debounced button press counter.
// A read-and-clear transaction passes through the input register, then its result is
// captured in the result register and presented on the master side.
// Throughput: one transaction per cycle while no read-and-clear waits on an untaken result,
// set by the state update (64-bit quiet-gap add and compare feeding the counters).
// Reset (rst_n, async, active low): counters, timestamps and phase cleared,
// quiet gaps back to 1000 us (edge) and 50000 us (button), pipeline emptied.
module rotary_encoder_with_button_counter (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [rebc_pkg::QUIET_W-1:0]     cfg_data,
    // event stream in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rebc_pkg::IN_DATA_W-1:0]   s_tdata,  // time_us[63:0], phase_a[64], phase_b[65], zero pad
    input  logic [1:0]                       s_tuser,  // cmd[1:0]
    // result stream out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rebc_pkg::OUT_DATA_W-1:0]  m_tdata   // position_count[31:0], press_count[63:32]
);
    import rebc_pkg::*;

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  item_take;
    logic [COUNT_W-1:0] out_position;
    logic [COUNT_W-1:0] out_presses;

    // unpack the incoming transaction; pad bits are dropped
    assign in_item.cmd     = cmd_t'(s_tuser);
    assign in_item.time_us = s_tdata[TIME_W-1:0];
    assign in_item.phase_a = s_tdata[TIME_W];
    assign in_item.phase_b = s_tdata[TIME_W+1];

    // input register: decouples the slave side from the state update, and
    // keeps accepting edge and button transactions while a result waits on
    // the master side; a second read-and-clear holds here until it is taken
    rebc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    // state update and result register; a read-and-clear only stalls
    // when the previous result has not been taken yet
    rebc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (reg_idx_t'(cfg_index)),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item         (item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_position (out_position),
        .out_presses  (out_presses)
    );

    assign m_tdata = {out_presses, out_position};

endmodule
